### rtl/gkd_pkg.sv
// Shared types, constants and the Gaussian table for the kernel density block.
// Depends on nothing; every other file but gkd_ram imports it.
`timescale 1ns / 1ps
package gkd_pkg;

   localparam int MAX_SAMPLES      = 1024;
   localparam int GAUSS_TABLE_SIZE = 256;

   localparam int VAL_W  = 16;
   localparam int BW_W   = 16;
   localparam int DENS_W = 24;
   localparam int OP_W   = 2;
   localparam int ADDR_W = $clog2(MAX_SAMPLES);
   localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
   localparam int IDX_W  = $clog2(GAUSS_TABLE_SIZE);
   // |x - s| needs one bit more than a sample; the index numerator is 64 * SIZE * d + h.
   localparam int DIFF_W = VAL_W + 1;
   localparam int NUM_W  = DIFF_W + 6 + IDX_W + 1;
   localparam int SUM_W  = DENS_W + CNT_W;
   localparam int DEN_W  = CNT_W + BW_W;
   localparam int QUO_W  = SUM_W + 10;

   localparam logic [BW_W-1:0]   BW_MIN      = BW_W'(256);
   localparam logic [DENS_W-1:0] DENSITY_MAX = '1;

   localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
   localparam logic [OP_W-1:0] OP_EVAL  = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]         kind;
      logic signed [VAL_W-1:0] value;
   } cmd_type;

   typedef logic [DENS_W-1:0] gauss_tab_type [GAUSS_TABLE_SIZE];

   // Long division by shift and subtract, used only while the table is built.
   function automatic logic [63:0] div_u64(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] q;
      logic [64:0] r;
      q = '0;
      r = '0;
      for (int i = 63; i >= 0; i--) begin
         r = {r[63:0], a[i]};
         if (r >= {1'b0, b}) begin
            r    = r - {1'b0, b};
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   // exp(f) in Q30 for f in [0, 1.0], Taylor series until a term vanishes.
   function automatic logic [63:0] exp_pos_q30(input logic [63:0] f);
      logic [63:0] sum;
      logic [63:0] term;
      logic        done;
      sum  = 64'd1 << 30;
      term = 64'd1 << 30;
      done = 1'b0;
      for (int k = 1; k < 40; k++) begin
         if (!done) begin
            term = div_u64((term * f) >> 30, 64'(k));
            if (term == 64'd0) begin
               done = 1'b1;
            end else begin
               sum = sum + term;
            end
         end
      end
      return sum;
   endfunction

   function automatic logic [63:0] exp_neg_q30(input logic [63:0] f);
      return div_u64(64'd1 << 60, exp_pos_q30(f));
   endfunction

   // Entry i holds exp(-u*u/2)/sqrt(2*pi) at u = 8*i/SIZE, rounded to Q0.24.
   function automatic gauss_tab_type build_gauss_tab();
      gauss_tab_type tab;
      logic [63:0]   em1;
      logic [63:0]   sz2;
      logic [63:0]   t;
      logic [63:0]   n;
      logic [63:0]   r;
      logic [63:0]   phi;
      em1 = exp_neg_q30(64'd1 << 30);
      sz2 = 64'(GAUSS_TABLE_SIZE) * 64'(GAUSS_TABLE_SIZE);
      for (int i = 0; i < GAUSS_TABLE_SIZE; i++) begin
         t = div_u64((64'd32 * 64'(i) * 64'(i)) << 30, sz2);
         n = t >> 30;
         r = exp_neg_q30(t & ((64'd1 << 30) - 64'd1));
         for (int j = 0; j < 32; j++) begin
            if (64'(j) < n) begin
               r = (r * em1) >> 30;
            end
         end
         phi    = (r * 64'd428361011) >> 30;
         tab[i] = DENS_W'((phi + 64'd32) >> 6);
      end
      return tab;
   endfunction

   localparam gauss_tab_type GAUSS_TAB = build_gauss_tab();

endpackage

### rtl/gkd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
module gkd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/gkd_front.sv
// Front end: accepts requests, drops unused opcodes and queues commands.
// Depends on gkd_pkg.
`timescale 1ns / 1ps
module gkd_front import gkd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [VAL_W-1:0] req_tdata,
   input  logic [OP_W-1:0]  req_tuser,
   output logic             cmd_valid,
   output cmd_type          cmd,
   input  logic             cmd_ready
);

   cmd_type     entry_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  fill_ff, fill_in;
   logic        accept, keep, push, pop;

   assign req_tready = (fill_ff != 2'd2);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      unique case (req_tuser)
         OP_LOAD, OP_EVAL, OP_CLEAR: keep = 1'b1;
         default:                    keep = 1'b0;
      endcase
   end

   assign push      = accept && keep;
   assign cmd_valid = (fill_ff != 2'd0);
   assign cmd       = entry_ff[rd_ptr_ff];
   assign pop       = cmd_valid && cmd_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      fill_in   = fill_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= '{kind: req_tuser, value: req_tdata};
      end
   end

endmodule

### rtl/gkd_idx.sv
// Pipelined table index unit: idx = (64*SIZE*|x-s| + h) / (2h), one sample per cycle.
// Depends on gkd_pkg.
`timescale 1ns / 1ps
module gkd_idx import gkd_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic signed [VAL_W-1:0] in_sample,
   input  logic signed [VAL_W-1:0] point,
   input  logic [BW_W-1:0]         bw,
   output logic                    out_valid,
   output logic [IDX_W-1:0]        out_idx,
   output logic                    busy
);

   logic [IDX_W:0]    v_ff;
   logic [IDX_W:0]    inr_ff;
   logic [NUM_W-1:0]  rem_ff [IDX_W+1];
   logic [IDX_W-1:0]  q_ff   [IDX_W+1];

   logic signed [DIFF_W-1:0] diff;
   logic [DIFF_W-1:0]        abs_diff;
   logic [NUM_W-1:0]         num;
   logic [NUM_W-1:0]         lim;

   // First stage: distance, numerator and the range check against SIZE.
   always_comb begin
      diff     = DIFF_W'(point) - DIFF_W'(in_sample);
      abs_diff = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
      num      = (NUM_W'(abs_diff) << (6 + IDX_W)) + NUM_W'(bw);
      lim      = NUM_W'(bw) << (IDX_W + 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else begin
         v_ff[0] <= in_valid;
      end
      inr_ff[0] <= (num < lim);
      rem_ff[0] <= num;
      q_ff[0]   <= '0;
   end

   // One quotient bit per stage, most significant first.
   for (genvar j = 1; j <= IDX_W; j++) begin : g_stage
      logic [NUM_W-1:0] dsh;
      logic             take;
      assign dsh  = NUM_W'({bw, 1'b0}) << (IDX_W - j);
      assign take = (rem_ff[j-1] >= dsh);
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[j] <= 1'b0;
         end else begin
            v_ff[j] <= v_ff[j-1];
         end
         inr_ff[j] <= inr_ff[j-1];
         rem_ff[j] <= take ? rem_ff[j-1] - dsh : rem_ff[j-1];
         q_ff[j]   <= q_ff[j-1] | (take ? IDX_W'(1) << (IDX_W - j) : IDX_W'(0));
      end
   end

   assign out_valid = v_ff[IDX_W] && inr_ff[IDX_W];
   assign out_idx   = q_ff[IDX_W];
   assign busy      = |v_ff;

endmodule

### rtl/gkd_back.sv
// Back end: sample store, evaluation sweep, final normalizing divide and result register.
// Depends on gkd_pkg, gkd_ram and gkd_idx.
`timescale 1ns / 1ps
module gkd_back import gkd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [BW_W-1:0]   csr_wdata,
   input  logic              cmd_valid,
   input  cmd_type           cmd,
   output logic              cmd_ready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [DENS_W-1:0] rsp_density,
   output logic              rsp_empty
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_RUN   = 3'd1;
   localparam logic [2:0] S_DRAIN = 3'd2;
   localparam logic [2:0] S_MUL   = 3'd3;
   localparam logic [2:0] S_PREP  = 3'd4;
   localparam logic [2:0] S_DIV   = 3'd5;
   localparam logic [2:0] S_OUT   = 3'd6;
   localparam int BIT_W = $clog2(QUO_W);

   logic [2:0]              state_ff, state_in;
   logic [BW_W-1:0]         bw_ff;
   logic [BW_W-1:0]         h_eff;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [ADDR_W-1:0]       addr_ff, addr_in;
   logic                    rd_valid_ff;
   logic signed [VAL_W-1:0] x_ff, x_in;
   logic [SUM_W-1:0]        sum_ff, sum_in;
   logic [DEN_W-1:0]        den_ff, den_in;
   logic [QUO_W-1:0]        numq_ff, numq_in;
   logic [DEN_W:0]          rem_ff, rem_in;
   logic [BIT_W-1:0]        bit_ff, bit_in;
   logic                    res_empty_ff, res_empty_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [DENS_W-1:0]       rsp_density_ff, rsp_density_in;
   logic                    rsp_empty_ff, rsp_empty_in;

   logic                    pop, wr_en;
   logic [VAL_W-1:0]        rd_data;
   logic                    idx_valid, idx_busy;
   logic [IDX_W-1:0]        idx;
   logic [DEN_W+1:0]        rem_sh, divisor;
   logic                    qbit;
   logic [DENS_W-1:0]       density_sat;

   assign h_eff     = (bw_ff < BW_MIN) ? BW_MIN : bw_ff;
   assign cmd_ready = (state_ff == S_IDLE);
   assign pop       = cmd_valid && cmd_ready;
   assign wr_en     = pop && (cmd.kind == OP_LOAD) && (count_ff < CNT_W'(MAX_SAMPLES));

   gkd_ram #(.WIDTH(VAL_W), .DEPTH(MAX_SAMPLES)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (cmd.value),
      .rd_en   (state_ff == S_RUN),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   gkd_idx u_idx (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rd_valid_ff),
      .in_sample (rd_data),
      .point     (x_ff),
      .bw        (h_eff),
      .out_valid (idx_valid),
      .out_idx   (idx),
      .busy      (idx_busy)
   );

   assign rem_sh      = {rem_ff, numq_ff[QUO_W-1]};
   assign divisor     = {1'b0, den_ff, 1'b0};
   assign qbit        = (rem_sh >= divisor);
   assign density_sat = (|numq_ff[QUO_W-1:DENS_W]) ? DENSITY_MAX : numq_ff[DENS_W-1:0];

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      addr_in        = addr_ff;
      x_in           = x_ff;
      sum_in         = idx_valid ? sum_ff + SUM_W'(GAUSS_TAB[idx]) : sum_ff;
      den_in         = den_ff;
      numq_in        = numq_ff;
      rem_in         = rem_ff;
      bit_in         = bit_ff;
      res_empty_in   = res_empty_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_density_in = rsp_density_ff;
      rsp_empty_in   = rsp_empty_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (pop) begin
               unique case (cmd.kind)
                  OP_LOAD: begin
                     if (wr_en) begin
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  OP_CLEAR: count_in = '0;
                  default: begin
                     x_in    = cmd.value;
                     addr_in = '0;
                     sum_in  = '0;
                     if (count_ff == '0) begin
                        res_empty_in = 1'b1;
                        state_in     = S_OUT;
                     end else begin
                        res_empty_in = 1'b0;
                        state_in     = S_RUN;
                     end
                  end
               endcase
            end
         end
         S_RUN: begin
            addr_in = addr_ff + ADDR_W'(1);
            if (CNT_W'(addr_ff) + CNT_W'(1) == count_ff) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (!rd_valid_ff && !idx_busy) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            den_in   = DEN_W'(count_ff) * DEN_W'(h_eff);
            state_in = S_PREP;
         end
         S_PREP: begin
            numq_in  = {sum_ff, 9'b0} + QUO_W'(den_ff);
            rem_in   = '0;
            bit_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            rem_in  = qbit ? (DEN_W+1)'(rem_sh - divisor) : rem_sh[DEN_W:0];
            numq_in = {numq_ff[QUO_W-2:0], qbit};
            bit_in  = bit_ff + BIT_W'(1);
            if (bit_ff == BIT_W'(QUO_W - 1)) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in   = 1'b1;
               rsp_density_in = res_empty_ff ? '0 : density_sat;
               rsp_empty_in   = res_empty_ff;
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         bw_ff        <= BW_MIN;
         count_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_valid_ff  <= (state_ff == S_RUN);
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            bw_ff <= csr_wdata;
         end
      end
      addr_ff        <= addr_in;
      x_ff           <= x_in;
      sum_ff         <= sum_in;
      den_ff         <= den_in;
      numq_ff        <= numq_in;
      rem_ff         <= rem_in;
      bit_ff         <= bit_in;
      res_empty_ff   <= res_empty_in;
      rsp_density_ff <= rsp_density_in;
      rsp_empty_ff   <= rsp_empty_in;
   end

   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_density = rsp_density_ff;
   assign rsp_empty   = rsp_empty_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_SAMPLES))
      else $error("sample count above store depth");

   a_run_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_RUN |-> count_ff != '0)
      else $error("sweep over an empty store");

   a_idx_in_sweep: assert property (@(posedge clock) disable iff (reset)
      idx_valid |-> (state_ff == S_RUN || state_ff == S_DRAIN))
      else $error("table index outside an evaluation");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_empty_ff |-> rsp_density_ff == '0)
      else $error("empty result with nonzero density");
`endif

endmodule

### rtl/gaussian_kernel_density_top.sv
// Top level of the Gaussian kernel density estimator.
// Depends on gkd_pkg, gkd_front and gkd_back.
`timescale 1ns / 1ps
// Usage:
// Requests arrive on the req_ stream. tuser carries the opcode (load a sample,
// evaluate the density at a point, clear the store); tdata carries the signed
// sample or point. Opcode 3 is accepted and discarded. Only an evaluate request
// produces a response on the rsp_ stream: tdata is the density in Q0.24 and
// tuser is the empty flag, set with zero density when the store is empty.
// The bandwidth register (Q8.8, values below 1.0 act as 1.0) is written through
// csr_we/csr_wdata while the block is idle, a rule for the user that the block
// does not enforce. A two-entry command queue sits between the front end and the
// back end, so requests keep being taken while the back end works or a response
// waits. Load and clear are handled in the back end's idle state. An evaluation
// reads the stored samples one per cycle through a pipelined index divider, then
// runs a bit-serial normalizing divide. Throughput is set by the single read port
// of the sample store.
// Reset is synchronous and active high; it empties the store, sets the
// bandwidth to 1.0 and drops any queued request or pending response. When the
// receiver stalls, the response is held and the back end waits before the next
// evaluation result, while the queue fills and then deasserts req_tready.
module gaussian_kernel_density_top import gkd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [15:0]       req_tdata,   // [15:0] value
   input  logic [1:0]        req_tuser,   // [1:0] opcode
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [23:0]       rsp_tdata,   // [23:0] density_q0_24
   output logic [0:0]        rsp_tuser,   // [0] empty_flag
   input  logic              csr_we,
   input  logic [15:0]       csr_wdata    // bandwidth_q8_8
);

   logic    cmd_valid;
   logic    cmd_ready;
   cmd_type cmd;
   logic    rsp_empty;

   // The front end classifies and queues requests.
   gkd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_ready  (cmd_ready)
   );

   // The back end owns the store, the evaluation sweep and the response register.
   gkd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .cmd_valid   (cmd_valid),
      .cmd         (cmd),
      .cmd_ready   (cmd_ready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_density (rsp_tdata),
      .rsp_empty   (rsp_empty)
   );

   assign rsp_tuser = rsp_empty;

endmodule

### dv/gaussian_kernel_density_top_tb.sv
// Self-checking testbench for the Gaussian kernel density estimator top level.
// Depends on gkd_pkg and gaussian_kernel_density_top; it predicts every density response.
`timescale 1ns / 1ps
module gaussian_kernel_density_top_tb;
   import gkd_pkg::*;

   // Opcode 3 is not defined by the block; it must be swallowed silently.
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 3000000;
   // Idle margin after the last response: a full-store evaluation plus slack.
   localparam int DRAIN_CYCLES = 1300;

   typedef struct {
      logic [OP_W-1:0]  op;
      logic [VAL_W-1:0] val;
   } request_type;

   typedef struct {
      logic [DENS_W-1:0] density;
      logic              empty;
   } density_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [15:0]       req_tdata = '0;
   logic [1:0]        req_tuser = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [23:0]       rsp_tdata;
   logic [0:0]        rsp_tuser;
   logic              csr_we = 1'b0;
   logic [15:0]       csr_wdata = '0;

   gaussian_kernel_density_top i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   request_type  pending_reqs[$];
   density_type  expected_densities[$];
   int           errors = 0;
   int           cycles = 0;
   int           send_idle = 0;
   int           recv_idle = 0;
   bit           hold_requests = 1'b0;
   bit           req_taken = 1'b0;

   // Predictor state: its own copy of the store, the count and the bandwidth.
   logic [DENS_W-1:0]       kernel_tab [GAUSS_TABLE_SIZE];
   logic signed [VAL_W-1:0] stored_samples [MAX_SAMPLES];
   int unsigned             stored_count = 0;
   logic [BW_W-1:0]         bandwidth = 16'd256;

   function automatic longint unsigned exp_plus(longint unsigned f);
      longint unsigned acc;
      longint unsigned term;
      acc  = 64'd1 << 30;
      term = 64'd1 << 30;
      for (int k = 1; k < 40; k++) begin
         term = ((term * f) >> 30) / k;
         if (term == 0) break;
         acc += term;
      end
      return acc;
   endfunction

   function automatic longint unsigned exp_minus(longint unsigned f);
      return (64'd1 << 60) / exp_plus(f);
   endfunction

   // Fills the kernel table with phi(8*i/SIZE) in Q0.24 using Q30 steps.
   task automatic fill_kernel_tab();
      longint unsigned em1;
      longint unsigned t;
      longint unsigned n;
      longint unsigned r;
      longint unsigned phi;
      em1 = exp_minus(64'd1 << 30);
      for (int i = 0; i < GAUSS_TABLE_SIZE; i++) begin
         t = ((64'd32 * i * i) << 30) / (GAUSS_TABLE_SIZE * GAUSS_TABLE_SIZE);
         n = t >> 30;
         r = exp_minus(t & ((64'd1 << 30) - 1));
         while (n > 0) begin
            r = (r * em1) >> 30;
            n--;
         end
         phi = (r * 64'd428361011) >> 30;
         kernel_tab[i] = DENS_W'((phi + 32) >> 6);
      end
   endtask

   function automatic density_type estimate_density(logic signed [VAL_W-1:0] x);
      density_type     res;
      longint unsigned h;
      longint unsigned acc;
      longint unsigned den;
      longint unsigned q;
      longint unsigned d;
      longint unsigned idx;
      longint          diff;
      res.empty   = 1'b0;
      res.density = '0;
      if (stored_count == 0) begin
         res.empty = 1'b1;
         return res;
      end
      h   = (bandwidth < 16'd256) ? 256 : bandwidth;
      acc = 0;
      for (int k = 0; k < stored_count; k++) begin
         diff = longint'(x) - longint'(stored_samples[k]);
         d    = (diff < 0) ? -diff : diff;
         idx  = (64 * GAUSS_TABLE_SIZE * d + h) / (2 * h);
         if (idx < GAUSS_TABLE_SIZE) acc += kernel_tab[idx];
      end
      den = stored_count * h;
      q   = (acc * 512 + den) / (2 * den);
      res.density = (q > 64'hFFFFFF) ? DENSITY_MAX : DENS_W'(q);
      return res;
   endfunction

   // Driver: presents requests at the falling edge, keeping tvalid up while
   // a request waits for tready.
   always @(negedge clock) begin
      request_type nxt;
      if (!reset) begin
         if (!req_tvalid || req_taken) begin
            if (pending_reqs.size() > 0 && !hold_requests &&
                $urandom_range(99) >= send_idle) begin
               nxt = pending_reqs.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= nxt.op;
               req_tdata  <= nxt.val;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle);
      end
   end

   // Monitor: at each rising edge it checks a response against the oldest
   // prediction and feeds an accepted request to the predictor.
   always @(posedge clock) begin
      density_type want;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
      req_taken = 1'b0;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_densities.size() == 0) begin
               $error("unexpected response density=%0d empty=%0d", rsp_tdata, rsp_tuser[0]);
               errors++;
            end else begin
               want = expected_densities.pop_front();
               if (rsp_tdata !== want.density) begin
                  $error("density_q0_24 expected %0d actual %0d", want.density, rsp_tdata);
                  errors++;
               end
               if (rsp_tuser[0] !== want.empty) begin
                  $error("empty_flag expected %0d actual %0d", want.empty, rsp_tuser[0]);
                  errors++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            req_taken = 1'b1;
            case (req_tuser)
               OP_LOAD: begin
                  if (stored_count < MAX_SAMPLES) begin
                     stored_samples[stored_count] = req_tdata;
                     stored_count++;
                  end
               end
               OP_EVAL: expected_densities = {expected_densities,
                                              estimate_density(req_tdata)};
               OP_CLEAR: stored_count = 0;
               default: ;
            endcase
         end
      end
   end

   task automatic queue_req(logic [OP_W-1:0] op, int v);
      request_type r;
      r.op  = op;
      r.val = VAL_W'(v);
      pending_reqs = {pending_reqs, r};
   endtask

   // Waits until every request is taken and every response is in, then
   // lets the back end finish any load or clear still in flight.
   task automatic wait_idle();
      while (pending_reqs.size() > 0 || req_tvalid || expected_densities.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_bandwidth(logic [BW_W-1:0] v);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      bandwidth  = v;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // Random traffic: bursts of samples clustered around a center with
   // evaluations near it, some full-range values, clears and unused opcodes.
   task automatic queue_random(int n);
      int center;
      int count;
      int spread;
      int roll;
      int v;
      count  = 0;
      center = $urandom_range(65535) - 32768;
      spread = $urandom_range(3000) + 50;
      for (int i = 0; i < n; i++) begin
         roll = $urandom_range(99);
         v = ($urandom_range(9) == 0) ? int'($urandom_range(65535)) - 32768
                                      : center + int'($urandom_range(2 * spread)) - spread;
         if (roll < 4 || count > 48) begin
            queue_req(OP_CLEAR, $urandom_range(65535));
            count  = 0;
            center = $urandom_range(65535) - 32768;
            spread = $urandom_range(3000) + 50;
         end else if (roll < 7) begin
            queue_req(OP_UNUSED, $urandom_range(65535));
         end else if (roll < 60) begin
            queue_req(OP_LOAD, v);
            count++;
         end else begin
            queue_req(OP_EVAL, v);
         end
      end
   endtask

   initial begin
      logic [BW_W-1:0] bw_list [6];
      fill_kernel_tab();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle = 14;
      recv_idle = 48;

      // Directed: empty store, extreme values, unused opcode, clear.
      queue_req(OP_EVAL, 0);
      queue_req(OP_LOAD, 32767);
      queue_req(OP_LOAD, -32768);
      queue_req(OP_EVAL, 0);
      queue_req(OP_EVAL, 32767);
      queue_req(OP_EVAL, -32768);
      queue_req(OP_LOAD, 0);
      queue_req(OP_LOAD, 0);
      queue_req(OP_LOAD, 1);
      queue_req(OP_EVAL, 0);
      queue_req(OP_UNUSED, 16'hFFFF);
      queue_req(OP_EVAL, 2);
      queue_req(OP_CLEAR, 0);
      queue_req(OP_EVAL, 5);
      queue_req(OP_LOAD, 100);
      queue_req(OP_EVAL, 100);
      queue_req(OP_EVAL, 101);
      queue_req(OP_EVAL, 2148);
      queue_req(OP_CLEAR, 0);
      wait_idle();

      // Large store: a long sweep with a wide bandwidth, then a clear.
      write_bandwidth(16'd4000);
      for (int i = 0; i < 320; i++)
         queue_req(OP_LOAD, int'($urandom_range(8000)) - 4000);
      for (int i = 0; i < 4; i++)
         queue_req(OP_EVAL, int'($urandom_range(9000)) - 4500);
      queue_req(OP_CLEAR, 0);
      queue_req(OP_EVAL, 7);

      // The sender holds back until every prediction has been answered.
      hold_requests = 1'b1;
      while (expected_densities.size() > 0 || req_tvalid) @(posedge clock);
      hold_requests = 1'b0;
      wait_idle();

      // Below 1.0 acts as 1.0; the maximum and reset values are covered too.
      bw_list[0] = 16'd0;
      bw_list[1] = 16'd255;
      bw_list[2] = 16'hFFFF;
      bw_list[3] = 16'd256;
      bw_list[4] = BW_W'($urandom_range(65535));
      bw_list[5] = BW_W'($urandom_range(2048, 256));
      for (int p = 0; p < 3; p++) begin
         send_idle = (p == 0) ? 14 : (p == 1) ? 48 : 0;
         recv_idle = (p == 0) ? 48 : (p == 1) ? 14 : 0;
         for (int b = 0; b < 2; b++) begin
            write_bandwidth(bw_list[2 * p + b]);
            queue_random(38);
            wait_idle();
         end
      end

      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

### files.f
rtl/gkd_pkg.sv
rtl/gkd_ram.sv
rtl/gkd_front.sv
rtl/gkd_idx.sv
rtl/gkd_back.sv
rtl/gaussian_kernel_density_top.sv
dv/gaussian_kernel_density_top_tb.sv
